// ===== rtl/core/pmts_pkg.sv =====
package pmts_pkg;

   localparam int CNT_W     = 16;
   localparam int OUT_IDX_W = 4;

   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_POP     = 3'd1;
   localparam logic [2:0] REQ_NOW_ID  = 3'd2;
   localparam logic [2:0] REQ_NOW_IDX = 3'd3;
   localparam logic [2:0] REQ_SOON_ID = 3'd4;
   localparam logic [2:0] REQ_LOOKUP  = 3'd5;
   localparam logic [2:0] REQ_LOAD    = 3'd6;

   localparam logic [CNT_W-1:0] NOW_LIMIT    = 16'hff00;
   localparam logic [CNT_W-1:0] FREE_MIN     = 16'd2;
   localparam logic [CNT_W-1:0] SOON_VALUE   = 16'd1;
   localparam logic [CNT_W-1:0] FREE_RESET   = 16'd200;
   localparam logic [CNT_W-1:0] MARKER_RESET = 16'hffff;

   localparam logic [1:0] CSR_FREE_PERIOD = 2'd0;
   localparam logic [1:0] CSR_ENTRY_COUNT = 2'd1;
   localparam logic [1:0] CSR_MARKER      = 2'd2;

   typedef enum logic [2:0] {
      ALU_TICK = 3'd0,
      ALU_POP  = 3'd1,
      ALU_NOW  = 3'd2,
      ALU_SOON = 3'd3,
      ALU_LOOK = 3'd4,
      ALU_FREE = 3'd5
   } alu_op_type;

   typedef struct packed {
      logic             hit;
      logic             wr;
      logic [CNT_W-1:0] cnt_new;
      logic             above_min;
      logic             nonzero;
   } alu_res_type;

   typedef struct packed {
      logic                 pop_valid;
      logic [OUT_IDX_W-1:0] out_index;
      logic [CNT_W-1:0]     out_id;
      logic                 id_found;
      logic                 free_to_send;
      logic                 immediate_free;
   } rsp_type;

endpackage

// ===== rtl/core/periodic_message_tx_scheduler.sv =====
// Channel  Dir  Transfer on          Payload
// req      in   tvalid & tready      tuser: req_type; tdata: msg_id, slot_index, slot_period
// rsp      out  tvalid & tready      tuser: pop_valid, id_found; tdata: index, id, flags
// csr      in   psel&penable&pwrite  free_time_period @0, entry_count @4, free_time_marker @8
//
// Tick, pop and id requests scan the slots in use one per cycle through the single read
// port of the slot memory. An id match or a due slot ends the scan early.
// A pop with nothing due and an expired free timer adds a round-robin free-time pass.
// Force by index, load and unknown requests skip the scan and go straight to the output
// state. One request at a time.
// The result register frees the input: a new request is taken while a result waits.
// Reset is synchronous; the slot table is not cleared and must be loaded before use.
module periodic_message_tx_scheduler import pmts_pkg::*; #(
   parameter int MAX_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // msg_id[15:0], slot_index[19:16], slot_period[35:20]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_index[3:0], out_id[19:4], free_to_send[20],
                                    // immediate_free[21]
   output logic [1:0]  rsp_tuser,   // pop_valid[0], id_found[1]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [CNT_W-1:0] free_period_ff, free_period_in;
   logic [4:0]       entry_count_ff, entry_count_in;
   logic [CNT_W-1:0] marker_ff, marker_in;
   logic             csr_wr;
   rsp_type          rsp;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      free_period_in = free_period_ff;
      entry_count_in = entry_count_ff;
      marker_in      = marker_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            CSR_FREE_PERIOD: free_period_in = csr_pwdata[15:0];
            CSR_ENTRY_COUNT: entry_count_in = csr_pwdata[4:0];
            CSR_MARKER:      marker_in      = csr_pwdata[15:0];
            default:         marker_in      = marker_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_period_ff <= FREE_RESET;
         entry_count_ff <= '0;
         marker_ff      <= MARKER_RESET;
      end else begin
         free_period_ff <= free_period_in;
         entry_count_ff <= entry_count_in;
         marker_ff      <= marker_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_FREE_PERIOD: csr_prdata = {16'd0, free_period_ff};
         CSR_ENTRY_COUNT: csr_prdata = {27'd0, entry_count_ff};
         CSR_MARKER:      csr_prdata = {16'd0, marker_ff};
         default:         csr_prdata = '0;
      endcase
   end

   pmts_seq #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_type         (req_tuser),
      .msg_id           (req_tdata[15:0]),
      .slot_index       (req_tdata[19:16]),
      .slot_period      (req_tdata[35:20]),
      .free_time_period (free_period_ff),
      .entry_count      (entry_count_ff),
      .free_time_marker (marker_ff),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp              (rsp)
   );

   assign rsp_tdata = {2'b00, rsp.immediate_free, rsp.free_to_send, rsp.out_id, rsp.out_index};
   assign rsp_tuser = {rsp.id_found, rsp.pop_valid};

endmodule

// ===== rtl/core/pmts_alu.sv =====
module pmts_alu import pmts_pkg::*; (
   input  alu_op_type       op,
   input  logic [CNT_W-1:0] cnt,
   input  logic [CNT_W-1:0] slot_id,
   input  logic [CNT_W-1:0] period,
   input  logic [CNT_W-1:0] key,
   input  logic [CNT_W-1:0] marker,
   output alu_res_type      res
);

   always_comb begin
      res           = '0;
      res.above_min = cnt > FREE_MIN;
      res.nonzero   = cnt != '0;
      case (op)
         ALU_TICK: begin
            res.wr      = (cnt != '0) && (cnt < NOW_LIMIT);
            res.cnt_new = cnt - 1'b1;
         end
         ALU_POP: begin
            res.hit     = cnt == '0;
            res.wr      = res.hit;
            res.cnt_new = period;
         end
         ALU_NOW: begin
            res.hit     = slot_id == key;
            res.wr      = res.hit;
            res.cnt_new = '0;
         end
         ALU_SOON: begin
            res.hit     = slot_id == key;
            res.wr      = res.hit;
            res.cnt_new = SOON_VALUE;
         end
         ALU_LOOK: begin
            res.hit = slot_id == key;
         end
         ALU_FREE: begin
            res.hit     = cnt == marker;
            res.wr      = res.hit;
            res.cnt_new = '0;
         end
         default: begin
            res.hit = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/pmts_slot_ram.sv =====
module pmts_slot_ram import pmts_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic [AW-1:0]    waddr,
   input  logic             we_all,
   input  logic             we_cnt,
   input  logic [CNT_W-1:0] wid,
   input  logic [CNT_W-1:0] wper,
   input  logic [CNT_W-1:0] wcnt,
   input  logic [AW-1:0]    raddr,
   output logic [CNT_W-1:0] rd_id,
   output logic [CNT_W-1:0] rd_per,
   output logic [CNT_W-1:0] rd_cnt
);

   logic [2*CNT_W-1:0] idper_mem [DEPTH];
   logic [CNT_W-1:0]   cnt_mem   [DEPTH];
   logic [CNT_W-1:0]   rd_id_ff;
   logic [CNT_W-1:0]   rd_per_ff;
   logic [CNT_W-1:0]   rd_cnt_ff;

   always_ff @(posedge clock) begin
      if (we_all) begin
         idper_mem[waddr] <= {wid, wper};
      end
      if (we_all || we_cnt) begin
         cnt_mem[waddr] <= wcnt;
      end
      {rd_id_ff, rd_per_ff} <= idper_mem[raddr];
      rd_cnt_ff             <= cnt_mem[raddr];
   end

   assign rd_id  = rd_id_ff;
   assign rd_per = rd_per_ff;
   assign rd_cnt = rd_cnt_ff;

endmodule

// ===== rtl/core/pmts_seq.sv =====
module pmts_seq import pmts_pkg::*; #(
   parameter int MAX_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_type,
   input  logic [CNT_W-1:0] msg_id,
   input  logic [3:0]       slot_index,
   input  logic [CNT_W-1:0] slot_period,
   input  logic [CNT_W-1:0] free_time_period,
   input  logic [4:0]       entry_count,
   input  logic [CNT_W-1:0] free_time_marker,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp
);

   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int PW = IW + 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_OUT  = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   alu_op_type       op_ff, op_in;
   logic [CNT_W-1:0] key_ff, key_in;
   logic [IW-1:0]    iss_ptr_ff, iss_ptr_in;
   logic [CW-1:0]    iss_left_ff, iss_left_in;
   logic             ev_ff, ev_in;
   logic [IW-1:0]    ev_idx_ff, ev_idx_in;
   logic [IW-1:0]    rr_ff, rr_in;
   logic [CNT_W-1:0] timer_ff, timer_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [CW-1:0]    n_slots;
   logic [PW-1:0]    n_ext;
   logic             slot_in_use;
   logic             slot_in_mem;
   logic [IW-1:0]    idx_addr;
   logic [PW-1:0]    ptr_inc;
   logic [IW-1:0]    ptr_adv;
   logic [PW-1:0]    rr_inc;
   logic [IW-1:0]    rr_adv;
   logic             rr_out;
   logic [CW-1:0]    free_cnt;
   logic [IW-1:0]    miss_ptr;
   logic             hit;

   logic [IW-1:0]    waddr;
   logic             we_all;
   logic             we_cnt;
   logic [CNT_W-1:0] wcnt;
   logic [CNT_W-1:0] rd_id;
   logic [CNT_W-1:0] rd_per;
   logic [CNT_W-1:0] rd_cnt;
   alu_res_type      alu_res;

   pmts_slot_ram #(
      .DEPTH (MAX_SLOTS),
      .AW    (IW)
   ) u_ram (
      .clock  (clock),
      .waddr  (waddr),
      .we_all (we_all),
      .we_cnt (we_cnt),
      .wid    (msg_id),
      .wper   (slot_period),
      .wcnt   (wcnt),
      .raddr  (iss_ptr_ff),
      .rd_id  (rd_id),
      .rd_per (rd_per),
      .rd_cnt (rd_cnt)
   );

   pmts_alu u_alu (
      .op      (op_ff),
      .cnt     (rd_cnt),
      .slot_id (rd_id),
      .period  (rd_per),
      .key     (key_ff),
      .marker  (free_time_marker),
      .res     (alu_res)
   );

   always_comb begin
      if (int'(entry_count) > MAX_SLOTS) begin
         n_slots = CW'(MAX_SLOTS);
      end else begin
         n_slots = CW'(entry_count);
      end
   end

   assign n_ext       = PW'(n_slots);
   assign slot_in_use = int'(slot_index) < int'(n_slots);
   assign slot_in_mem = int'(slot_index) < MAX_SLOTS;
   assign idx_addr    = IW'(slot_index);
   assign ptr_inc     = PW'(iss_ptr_ff) + 1'b1;
   assign ptr_adv     = (ptr_inc >= n_ext) ? '0 : IW'(ptr_inc);
   assign rr_inc      = PW'(rr_ff) + 1'b1;
   assign rr_adv      = (rr_inc >= n_ext) ? '0 : IW'(rr_inc);
   assign rr_out      = PW'(rr_ff) >= n_ext;
   assign free_cnt    = rr_out ? n_slots : n_slots - 1'b1;
   assign miss_ptr    = !rr_out ? rr_ff :
                        (n_slots == '0) ? '0 : IW'(n_slots - 1'b1);
   assign hit         = ev_ff && alu_res.hit;
   assign req_ready   = state_ff == S_IDLE;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      iss_ptr_in   = iss_ptr_ff;
      iss_left_in  = iss_left_ff;
      ev_in        = 1'b0;
      ev_idx_in    = ev_idx_ff;
      rr_in        = rr_ff;
      timer_in     = timer_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      waddr        = ev_idx_ff;
      we_all       = 1'b0;
      we_cnt       = 1'b0;
      wcnt         = alu_res.cnt_new;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in      = '0;
               key_in      = msg_id;
               iss_ptr_in  = '0;
               iss_left_in = n_slots;
               state_in    = S_SCAN;
               case (req_type)
                  REQ_TICK: begin
                     op_in = ALU_TICK;
                     if (timer_ff != '0) begin
                        timer_in = timer_ff - 1'b1;
                     end
                  end
                  REQ_POP:     op_in = ALU_POP;
                  REQ_NOW_ID:  op_in = ALU_NOW;
                  REQ_SOON_ID: op_in = ALU_SOON;
                  REQ_LOOKUP:  op_in = ALU_LOOK;
                  REQ_NOW_IDX: begin
                     state_in = S_OUT;
                     if (slot_in_use) begin
                        we_cnt = 1'b1;
                        waddr  = idx_addr;
                        wcnt   = '0;
                     end
                  end
                  REQ_LOAD: begin
                     state_in = S_OUT;
                     if (slot_in_mem) begin
                        we_all = 1'b1;
                        waddr  = idx_addr;
                        wcnt   = slot_period;
                     end
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_SCAN: begin
            if (iss_left_ff != '0) begin
               ev_in       = 1'b1;
               ev_idx_in   = iss_ptr_ff;
               iss_ptr_in  = ptr_adv;
               iss_left_in = iss_left_ff - 1'b1;
            end
            we_cnt = ev_ff && alu_res.wr;
            if (hit) begin
               state_in = S_OUT;
               ev_in    = 1'b0;
               case (op_ff)
                  ALU_POP: begin
                     res_in.pop_valid = 1'b1;
                     res_in.out_index = OUT_IDX_W'(ev_idx_ff);
                     res_in.out_id    = rd_id;
                  end
                  ALU_SOON: res_in.id_found = 1'b1;
                  ALU_LOOK: begin
                     res_in.out_index      = OUT_IDX_W'(ev_idx_ff);
                     res_in.id_found       = 1'b1;
                     res_in.free_to_send   = alu_res.above_min;
                     res_in.immediate_free = alu_res.nonzero;
                  end
                  ALU_FREE: rr_in = ev_idx_ff;
                  default:  rr_in = rr_ff;
               endcase
            end else if (iss_left_ff == '0) begin
               state_in = S_OUT;
               ev_in    = 1'b0;
               if (op_ff == ALU_POP && timer_ff == '0) begin
                  // nothing due and free timer expired: free-time round-robin pass
                  state_in    = S_SCAN;
                  op_in       = ALU_FREE;
                  timer_in    = free_time_period;
                  iss_ptr_in  = rr_adv;
                  iss_left_in = free_cnt;
               end else if (op_ff == ALU_FREE) begin
                  rr_in = miss_ptr;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= ALU_TICK;
         ev_ff        <= 1'b0;
         rr_ff        <= '0;
         timer_ff     <= FREE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         ev_ff        <= ev_in;
         rr_ff        <= rr_in;
         timer_ff     <= timer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      iss_ptr_ff  <= iss_ptr_in;
      iss_left_ff <= iss_left_in;
      ev_idx_ff   <= ev_idx_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_ev_in_scan : assert property (@(posedge clock) disable iff (reset)
      ev_ff |-> state_ff == S_SCAN)
      else $error("slot evaluation outside scan");

   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result loaded outside output state");

   a_tick_timer : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(req_valid && req_ready && req_type == REQ_TICK))
      |-> timer_ff <= $past(timer_ff))
      else $error("free timer grew on tick");

   a_pop_excl : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.pop_valid) |-> !rsp_ff.id_found && !rsp_ff.free_to_send)
      else $error("pop result carries lookup flags");

endmodule

// ===== test/periodic_message_tx_scheduler_tb.sv =====
module periodic_message_tx_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pmts_pkg::*;

   localparam int SLOTS        = 16;
   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 400;

   localparam logic [2:0] REQ_UNKNOWN = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] msg_id;
      logic [3:0]  slot;
      logic [15:0] period;
   } sched_req_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;
   logic [2:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   periodic_message_tx_scheduler #(.MAX_SLOTS(SLOTS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // scheduler mirror
   logic [15:0] tbl_id     [SLOTS];
   logic [15:0] tbl_period [SLOTS];
   logic [15:0] tbl_cnt    [SLOTS];
   logic [15:0] free_tmr;
   int unsigned rr_ptr;

   logic [15:0] cfg_free_period;
   logic [4:0]  cfg_entries;
   logic [15:0] cfg_marker;

   sched_req_type req_backlog [$];
   rsp_type       answer_q    [$];
   sched_req_type in_flight;
   rsp_type       got_rsp;
   rsp_type       want_rsp;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int queued_count   = 0;
   int accepted_count = 0;
   int result_count   = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int hold_left      = 0;
   int hold_count     = 0;
   bit hold_req       = 1'b0;
   int scan_count     = 0;
   int due_count      = 0;
   int hit_count      = 0;

   function automatic void reset_mirror();
      cfg_free_period = FREE_RESET;
      cfg_entries     = '0;
      cfg_marker      = MARKER_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_id[i]     = '0;
         tbl_period[i] = '0;
         tbl_cnt[i]    = '0;
      end
      free_tmr = FREE_RESET;
      rr_ptr   = 0;
   endfunction

   function automatic int unsigned slots_in_use();
      return (cfg_entries > SLOTS) ? SLOTS : cfg_entries;
   endfunction

   function automatic int unsigned find_slot(logic [15:0] id);
      int unsigned n;
      int unsigned hit;
      n   = slots_in_use();
      hit = SLOTS;
      for (int unsigned i = 0; i < n && hit == SLOTS; i++)
         if (tbl_id[i] == id) hit = i;
      return hit;
   endfunction

   function automatic int unsigned next_slot(int unsigned p, int unsigned n);
      return (p + 1 >= n) ? 0 : p + 1;
   endfunction

   // free-time round robin: reload timer, release next marked slot
   function automatic void free_time_pass();
      int unsigned n;
      int unsigned start;
      int unsigned p;
      bit          done;
      n     = slots_in_use();
      start = rr_ptr;
      p     = next_slot(start, n);
      done  = 1'b0;
      free_tmr = cfg_free_period;
      scan_count++;
      for (int unsigned k = 0; k < n && !done; k++) begin
         if (p == start) begin
            done = 1'b1;
         end else if (tbl_cnt[p] == cfg_marker) begin
            tbl_cnt[p] = '0;
            done = 1'b1;
         end else if (k + 1 < n) begin
            p = next_slot(p, n);
         end
      end
      rr_ptr = p;
   endfunction

   function automatic rsp_type schedule_request(sched_req_type r);
      rsp_type     res;
      int unsigned n;
      int unsigned s;
      res = '0;
      n   = slots_in_use();
      case (r.kind)
         REQ_TICK: begin
            for (int unsigned i = 0; i < n; i++)
               if (tbl_cnt[i] != 0 && tbl_cnt[i] < NOW_LIMIT) tbl_cnt[i] = tbl_cnt[i] - 1'b1;
            if (free_tmr != 0) free_tmr = free_tmr - 1'b1;
         end
         REQ_POP: begin
            for (int unsigned i = 0; i < n && !res.pop_valid; i++)
               if (tbl_cnt[i] == 0) begin
                  tbl_cnt[i]    = tbl_period[i];
                  res.pop_valid = 1'b1;
                  res.out_index = 4'(i);
                  res.out_id    = tbl_id[i];
               end
            if (res.pop_valid) due_count++;
            else if (free_tmr == 0) free_time_pass();
         end
         REQ_NOW_ID: begin
            s = find_slot(r.msg_id);
            if (s < SLOTS) tbl_cnt[s] = '0;
         end
         REQ_NOW_IDX: begin
            if (r.slot < n) tbl_cnt[r.slot] = '0;
         end
         REQ_SOON_ID: begin
            s = find_slot(r.msg_id);
            if (s < SLOTS) begin
               tbl_cnt[s]   = SOON_VALUE;
               res.id_found = 1'b1;
               hit_count++;
            end
         end
         REQ_LOOKUP: begin
            s = find_slot(r.msg_id);
            if (s < SLOTS) begin
               res.out_index      = 4'(s);
               res.id_found       = 1'b1;
               res.free_to_send   = tbl_cnt[s] > FREE_MIN;
               res.immediate_free = tbl_cnt[s] != 0;
               hit_count++;
            end
         end
         REQ_LOAD: begin
            tbl_id[r.slot]     = r.msg_id;
            tbl_period[r.slot] = r.period;
            tbl_cnt[r.slot]    = r.period;
         end
         default: ;
      endcase
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            answer_q.push_back(schedule_request(in_flight));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = req_backlog.pop_front();
               req_tdata  <= {4'b0, in_flight.period, in_flight.slot, in_flight.msg_id};
               req_tuser  <= in_flight.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.pop_valid      = rsp_tuser[0];
            got_rsp.id_found       = rsp_tuser[1];
            got_rsp.out_index      = rsp_tdata[3:0];
            got_rsp.out_id         = rsp_tdata[19:4];
            got_rsp.free_to_send   = rsp_tdata[20];
            got_rsp.immediate_free = rsp_tdata[21];
            result_count++;
            if (answer_q.size() == 0) begin
               $display("%0t: unexpected result transfer tuser=%b tdata=%h",
                        $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want_rsp = answer_q.pop_front();
               if (got_rsp !== want_rsp) begin
                  $display("%0t: result mismatch exp pop=%b idx=%0d id=%h found=%b fts=%b imm=%b",
                           $time, want_rsp.pop_valid, want_rsp.out_index, want_rsp.out_id,
                           want_rsp.id_found, want_rsp.free_to_send, want_rsp.immediate_free);
                  $display("%0t:                 got pop=%b idx=%0d id=%h found=%b fts=%b imm=%b",
                           $time, got_rsp.pop_valid, got_rsp.out_index, got_rsp.out_id,
                           got_rsp.id_found, got_rsp.free_to_send, got_rsp.immediate_free);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_req && hold_count == 0) begin
            hold_left = HOLD_CYCLES - 1;
            hold_count++;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic csr_write(logic [1:0] reg_sel, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (reg_sel)
         CSR_FREE_PERIOD: cfg_free_period = value[15:0];
         CSR_ENTRY_COUNT: cfg_entries     = value[4:0];
         CSR_MARKER:      cfg_marker      = value[15:0];
         default: ;
      endcase
   endtask

   task automatic csr_check(logic [1:0] reg_sel, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {reg_sel, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value) begin
         $display("%0t: csr readback reg %0d exp %h got %h", $time, reg_sel, value, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(logic [15:0] period, logic [4:0] entries, logic [15:0] marker);
      csr_write(CSR_FREE_PERIOD, {16'b0, period});
      csr_write(CSR_ENTRY_COUNT, {27'b0, entries});
      csr_write(CSR_MARKER, {16'b0, marker});
      csr_check(CSR_FREE_PERIOD, {16'b0, cfg_free_period});
      csr_check(CSR_ENTRY_COUNT, {27'b0, cfg_entries});
      csr_check(CSR_MARKER, {16'b0, cfg_marker});
   endtask

   task automatic wait_drain();
      while (accepted_count != queued_count || answer_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send(logic [2:0] kind, logic [15:0] id, logic [3:0] slot, logic [15:0] period);
      sched_req_type r;
      r.kind   = kind;
      r.msg_id = id;
      r.slot   = slot;
      r.period = period;
      req_backlog.push_back(r);
      queued_count++;
   endtask

   // ids mostly from a small set so duplicates and matches are common
   function automatic logic [15:0] pick_id();
      if ($urandom_range(99) < 85) begin
         case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h1234;
            3:       return 16'habcd;
            4:       return 16'h5555;
            default: return 16'h00a5;
         endcase
      end
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_period();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 40) return 16'($urandom_range(6));
      if (sel < 60) return cfg_marker;
      if (sel < 70) return 16'hff00 + 16'($urandom_range(255));
      if (sel < 78) return 16'h0000;
      return 16'($urandom);
   endfunction

   task automatic send_random(int count);
      int unsigned sel;
      logic [2:0]  kind;
      logic [15:0] id;
      logic [15:0] period;
      repeat (count) begin
         sel    = $urandom_range(99);
         id     = 16'($urandom);
         period = 16'($urandom);
         if (sel < 35) kind = REQ_TICK;
         else if (sel < 60) kind = REQ_POP;
         else if (sel < 66) kind = REQ_NOW_ID;
         else if (sel < 72) kind = REQ_NOW_IDX;
         else if (sel < 78) kind = REQ_SOON_ID;
         else if (sel < 88) kind = REQ_LOOKUP;
         else if (sel < 97) kind = REQ_LOAD;
         else kind = REQ_UNKNOWN;
         if (kind == REQ_NOW_ID || kind == REQ_SOON_ID || kind == REQ_LOOKUP ||
             kind == REQ_LOAD)
            id = pick_id();
         if (kind == REQ_LOAD) period = pick_period();
         send(kind, id, 4'($urandom), period);
      end
   endtask

   initial begin
      reset_mirror();
      send_idle_pct = 9;
      recv_idle_pct = 65;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // no slots in use, then fill the whole table
      send(REQ_TICK, 16'h0000, 4'd0, 16'h0000);
      send(REQ_POP, 16'h0000, 4'd0, 16'h0000);
      send(REQ_NOW_ID, 16'h0000, 4'd0, 16'h0000);
      send(REQ_NOW_IDX, 16'h0000, 4'd0, 16'h0000);
      send(REQ_SOON_ID, 16'hffff, 4'd0, 16'h0000);
      send(REQ_LOOKUP, 16'h1234, 4'd0, 16'h0000);
      send(REQ_UNKNOWN, 16'hffff, 4'hf, 16'hffff);
      send(REQ_LOAD, 16'h0000, 4'd0, 16'h0000);
      send(REQ_LOAD, 16'hffff, 4'd1, 16'hffff);
      send(REQ_LOAD, 16'h1234, 4'd2, 16'h0003);
      send(REQ_LOAD, 16'h1234, 4'd3, 16'h0001);
      send(REQ_LOAD, 16'habcd, 4'd4, NOW_LIMIT);
      send(REQ_LOAD, 16'h5555, 4'd5, 16'hfffe);
      send(REQ_LOAD, 16'h00a5, 4'd6, 16'h0002);
      for (int i = 7; i < 15; i++) send(REQ_LOAD, 16'h0100 + 16'(i), 4'(i), 16'(i));
      send(REQ_LOAD, 16'hffff, 4'd15, 16'hffff);
      wait_drain();

      configure(16'd0, 5'd4, MARKER_RESET);
      send(REQ_POP, 16'h0000, 4'd0, 16'h0000);
      send(REQ_LOOKUP, 16'h1234, 4'd0, 16'h0000);
      send(REQ_SOON_ID, 16'h1234, 4'd0, 16'h0000);
      send(REQ_LOOKUP, 16'h1234, 4'd0, 16'h0000);
      send(REQ_NOW_IDX, 16'h0000, 4'd3, 16'h0000);
      send(REQ_NOW_IDX, 16'h0000, 4'd9, 16'h0000);
      send(REQ_NOW_ID, 16'hffff, 4'd0, 16'h0000);
      send(REQ_LOOKUP, 16'hffff, 4'd0, 16'h0000);
      send(REQ_LOOKUP, 16'h7777, 4'd0, 16'h0000);
      send(REQ_SOON_ID, 16'h7777, 4'd0, 16'h0000);
      send(REQ_TICK, 16'h0000, 4'd0, 16'h0000);
      send(REQ_LOAD, 16'h0000, 4'd0, 16'h0005);
      // run the free timer down from its reset value
      for (int i = 0; i < 200; i++) begin
         send(REQ_TICK, 16'h0000, 4'd0, 16'h0000);
         if (i % 8 == 7) send(REQ_POP, 16'h0000, 4'd0, 16'h0000);
      end
      send_random(80);
      wait_drain();

      configure(16'd3, 5'd16, 16'hff00);
      send_random(130);
      wait_drain();

      send_idle_pct = 65;
      recv_idle_pct = 9;
      configure(16'd1, 5'd0, 16'hff80);
      send_random(50);
      wait_drain();

      configure(16'hffff, 5'd31, MARKER_RESET);
      send_random(100);
      wait_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(16'd2, 5'd7, 16'hff00 + 16'($urandom_range(255)));
      send_random(120);
      hold_req = 1'b1;
      wait_drain();

      configure(16'd0, 5'd1, MARKER_RESET);
      send_random(50);
      wait_drain();

      repeat (20) @(posedge clock);
      $display("Sent %0d requests, checked %0d results in %0d cycles, %0d long receiver hold-offs.",
               accepted_count, result_count, cycle_count, hold_count);
      $display("Pops with a due slot: %0d, id matches: %0d, free-time passes: %0d.",
               due_count, hit_count, scan_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== periodic_message_tx_scheduler.f =====
rtl/core/pmts_pkg.sv
rtl/core/pmts_alu.sv
rtl/core/pmts_slot_ram.sv
rtl/core/pmts_seq.sv
rtl/core/periodic_message_tx_scheduler.sv
test/periodic_message_tx_scheduler_tb.sv
